// ===== rtl/sbg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sbg_pkg;

  // Default table depth (power of two) and phase accumulator width
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 32;

  // Serial divider widths: largest dividend is mag * 12000 * num (44 bits),
  // largest divisor is 32767 * fade (30 bits)
  localparam int DVD_W = 44;
  localparam int DVS_W = 30;

  // Q30 fixed-point constants for the sine evaluation
  localparam logic [31:0] Q30_ONE     = 32'd1073741824;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [14:0] FULL_SCALE  = 15'd32767;
  localparam logic [13:0] AMPLITUDE   = 14'd12000;

  // Last Horner step index (five steps: 110, 72, 42, 20, 6)
  localparam logic [2:0] HORNER_LAST = 3'd4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PHASE_STEP  = 2'd0,
    CFG_CLIP_LENGTH = 2'd1,
    CFG_FADE_LENGTH = 2'd2
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_XMUL,
    S_X2MUL,
    S_HDIV,
    S_HWAIT,
    S_HMUL,
    S_SMUL,
    S_VMUL,
    S_VRND,
    S_AMUL,
    S_NMUL,
    S_DMUL,
    S_FDIV,
    S_FWAIT,
    S_DONE
  } sbg_state_t;

  // Reciprocals of the Horner divisors (110, 72, 42, 20, 6), innermost first.
  // floor(n / d) = (n * m) >> s is exact for every dividend the series sees
  // (below 2.7e9).
  function automatic logic [31:0] horner_magic(input logic [2:0] step);
    logic [31:0] m;
    case (step)
      3'd0:    m = 32'd2498890064;
      3'd1:    m = 32'd3817748708;
      3'd2:    m = 32'd3272356036;
      3'd3:    m = 32'd3435973837;
      default: m = 32'd2863311531;
    endcase
    return m;
  endfunction

  // Quotient taken from the reciprocal product: shifts 38, 38, 37, 36, 34
  function automatic logic [30:0] horner_quot(input logic [2:0] step,
                                              input logic [63:0] p);
    logic [30:0] q;
    case (step)
      3'd0:    q = 31'(p[63:38]);
      3'd1:    q = 31'(p[63:38]);
      3'd2:    q = 31'(p[63:37]);
      3'd3:    q = 31'(p[63:36]);
      default: q = 31'(p[63:34]);
    endcase
    return q;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sbg_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module sbg_div import sbg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] dvd;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   diff;
  logic             fits;
  logic [DVS_W-1:0] rem_next;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    rem_sh   = {rem, dvd[DVD_W-1]};
    diff     = rem_sh - {1'b0, dvs};
    fits     = !diff[DVS_W];
    rem_next = fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[DVD_W-2:0], fits};
    end
  end

  assign quotient = dvd;

endmodule

`default_nettype wire

// ===== rtl/sine_beep_generator_unit.sv =====
// Tone clip generator: each accepted item (a tick, with restart) yields one
// Q15-derived PCM sample of a linearly faded sine tone, or nothing once the
// clip has ended and no restart is given. A phase accumulator steps by
// phase_step per sample; its top bits pick a point on the sine wave, which is
// evaluated on the fly by a Horner-form Taylor series (Q30) rather than read
// from a stored table. One 32x32 multiplier and one serial divider are
// shared under a small sequencer; the Horner divisions by constants are
// done on the multiplier by reciprocal multiplication, and the divider only
// does the final envelope scaling. An item that yields a sample keeps
// in_stall high through the whole sequence, the wait on the divider
// included, until its sample is loaded into the output register, later if
// the previous sample still sits unaccepted there. An item that yields
// nothing leaves in_stall low. The finished sample sits in an output
// register, so the next item may be taken while it waits. SINE_TABLE_DEPTH
// must be a power of two no larger than 2**PHASE_BITS. Configuration writes
// are taken at any time but are meant to be made while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module sine_beep_generator_unit import sbg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        restart,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [14:0] sample,
  output logic             last
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

  // Configuration registers
  logic [31:0] phase_step;
  logic [15:0] clip_length;
  logic [14:0] fade_length;

  // Clip state
  logic [15:0]           sample_index, sample_index_next;
  logic [PHASE_BITS-1:0] phase_acc, phase_acc_next;
  logic                  clip_done, clip_done_next;

  sbg_state_t state, state_next;

  // Datapath registers
  logic [30:0] r;
  logic [1:0]  quad;
  logic [30:0] x;
  logic [31:0] x2;
  logic [30:0] b;
  logic [2:0]  hstep;
  logic [63:0] prod;
  logic [14:0] num;
  logic [14:0] den;
  logic [14:0] mag;
  logic        neg;
  logic        last_p;
  logic [DVD_W-1:0] numer;

  // Shared units
  logic [31:0]      mul_a, mul_b;
  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_quot;
  logic [DVS_W-1:0] div_dvs;

  // Accept-time decode
  logic                  in_acc, run, out_load;
  logic [15:0]           si_eff;
  logic [PHASE_BITS-1:0] ph_eff, step_ext;
  logic                  done_eff;
  logic [IDX_W-1:0]      k;
  logic [31:0]           turn;
  logic [30:0]           r_init;
  logic signed [16:0]    len_m_fade;
  logic [14:0]           num_init, den_init;
  logic                  last_init;
  logic [45:0]           rnd;
  logic [15:0]           v;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);
  assign step_ext  = PHASE_BITS'(phase_step);

  // Restart overrides the stored position; decode envelope and sine point
  always_comb begin
    si_eff     = restart ? 16'd0 : sample_index;
    ph_eff     = restart ? '0 : phase_acc;
    done_eff   = restart ? 1'b0 : clip_done;
    run        = in_acc && !done_eff && (si_eff < clip_length);
    k          = ph_eff[PHASE_BITS-1 -: IDX_W];
    turn       = 32'(k) << (32 - IDX_W);
    r_init     = turn[30] ? (Q30_ONE[30:0] - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
    len_m_fade = $signed({1'b0, clip_length}) - $signed({2'b0, fade_length});
    last_init  = (({1'b0, si_eff} + 17'd1) == {1'b0, clip_length});
    if (fade_length == 15'd0) begin
      num_init = 15'd1;
      den_init = 15'd1;
    end else begin
      den_init = fade_length;
      if ($signed({1'b0, si_eff}) > len_m_fade) begin
        num_init = 15'(clip_length - si_eff);
      end else if (si_eff < {1'b0, fade_length}) begin
        num_init = si_eff[14:0];
      end else begin
        num_init = fade_length;
      end
    end
  end

  // Clip position update at accept
  always_comb begin
    sample_index_next = sample_index;
    phase_acc_next    = phase_acc;
    clip_done_next    = clip_done;
    if (in_acc) begin
      sample_index_next = si_eff;
      phase_acc_next    = ph_eff;
      clip_done_next    = done_eff;
      if (!done_eff) begin
        if (si_eff >= clip_length) begin
          clip_done_next = 1'b1;
        end else begin
          sample_index_next = si_eff + 16'd1;
          phase_acc_next    = ph_eff + step_ext;
          if (last_init) begin
            clip_done_next = 1'b1;
          end
        end
      end
    end
  end

  // Sequencer: next state and shared unit operands
  always_comb begin
    state_next = state;
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    case (state)
      S_IDLE: begin
        if (run) state_next = S_XMUL;
      end
      S_XMUL: begin
        mul_a      = {1'b0, r};
        mul_b      = HALF_PI_Q30;
        state_next = S_X2MUL;
      end
      S_X2MUL: begin
        mul_a      = prod[61:30];
        mul_b      = prod[61:30];
        state_next = S_HDIV;
      end
      S_HDIV: begin
        // divide by the Horner constant through its reciprocal
        mul_a      = prod[61:30];
        mul_b      = horner_magic(hstep);
        state_next = S_HWAIT;
      end
      S_HWAIT: begin
        state_next = (hstep == HORNER_LAST) ? S_SMUL : S_HMUL;
      end
      S_HMUL: begin
        mul_a      = x2;
        mul_b      = {1'b0, b};
        state_next = S_HDIV;
      end
      S_SMUL: begin
        mul_a      = {1'b0, x};
        mul_b      = {1'b0, b};
        state_next = S_VMUL;
      end
      S_VMUL: begin
        mul_a      = prod[61:30];
        mul_b      = 32'(FULL_SCALE);
        state_next = S_VRND;
      end
      S_VRND: begin
        state_next = S_AMUL;
      end
      S_AMUL: begin
        mul_a      = 32'(mag);
        mul_b      = 32'(AMPLITUDE);
        state_next = S_NMUL;
      end
      S_NMUL: begin
        mul_a      = prod[31:0];
        mul_b      = 32'(num);
        state_next = S_DMUL;
      end
      S_DMUL: begin
        mul_a      = 32'(FULL_SCALE);
        mul_b      = 32'(den);
        state_next = S_FDIV;
      end
      S_FDIV: begin
        div_start  = 1'b1;
        div_dvd    = numer;
        div_dvs    = prod[DVS_W-1:0];
        state_next = S_FWAIT;
      end
      S_FWAIT: begin
        if (div_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      sample_index <= 16'd0;
      phase_acc    <= '0;
      clip_done    <= 1'b1;
      phase_step   <= 32'd214748365;
      clip_length  <= 16'd3200;
      fade_length  <= 15'd160;
    end else begin
      state        <= state_next;
      sample_index <= sample_index_next;
      phase_acc    <= phase_acc_next;
      clip_done    <= clip_done_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_PHASE_STEP:  phase_step  <= cfg_data;
          CFG_CLIP_LENGTH: clip_length <= cfg_data[15:0];
          CFG_FADE_LENGTH: fade_length <= cfg_data[14:0];
          default: ;
        endcase
      end
    end
  end

  // Rounding of the Q30 sine to full scale
  always_comb begin
    rnd = prod[45:0] + 46'(Q30_ONE >> 1);
    v   = rnd[45:30];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        r      <= r_init;
        quad   <= turn[31:30];
        num    <= num_init;
        den    <= den_init;
        last_p <= last_init;
        hstep  <= 3'd0;
      end
      S_X2MUL: begin
        x <= prod[60:30];
      end
      S_HDIV: begin
        if (hstep == 3'd0) x2 <= prod[61:30];
      end
      S_HWAIT: begin
        b     <= Q30_ONE[30:0] - horner_quot(hstep, prod);
        hstep <= hstep + 3'd1;
      end
      S_VRND: begin
        mag <= (v > {1'b0, FULL_SCALE}) ? FULL_SCALE : v[14:0];
        neg <= quad[1];
      end
      S_DMUL: begin
        numer <= prod[DVD_W-1:0];
      end
      S_FWAIT: begin
        if (div_done) begin
          mag <= (div_quot > DVD_W'(AMPLITUDE)) ? 15'(AMPLITUDE) : div_quot[14:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      sample <= neg ? $signed(15'd0 - mag) : $signed(mag);
      last   <= last_p;
    end
  end

  sbg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Divider results only arrive where the sequencer waits for them
  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_FWAIT))
    else $error("divider finished outside a wait state");

  // Horner loop never runs past its last step
  a_hstep_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_HWAIT) |-> (hstep <= HORNER_LAST))
    else $error("Horner step out of range");

  // Samples stay within the amplitude
  a_sample_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(sample) <= 15'sd12000 && $signed(sample) >= -15'sd12000))
    else $error("sample beyond amplitude");

  // A new result only comes from a finished computation
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE))
    else $error("result without finished computation");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sbg_pkg::*;

  localparam int LUT_DEPTH       = SINE_TABLE_DEPTH_DEF;
  localparam int PHASE_W         = PHASE_BITS_DEF;
  localparam int RANDOM_RESULTS  = 500;
  localparam int SETTLE_CYCLES   = 600;
  localparam int PRESSURE_HOLD   = 2500;
  localparam int CYCLE_LIMIT     = 1500000;
  localparam int IDLE_PCT        = 31;
  localparam int TICKS_PER_PHASE = 60;
  // index with no register behind it; writes to it are ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef longint unsigned u64_t;

  localparam u64_t Q30_UNIT    = 64'd1073741824;
  localparam u64_t HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t PEAK_CODE   = 64'd32767;
  localparam u64_t TONE_LEVEL  = 64'd12000;

  typedef struct packed {
    logic signed [14:0] sample;
    logic               last;
  } tone_result_t;

  typedef enum {ROW_CFG, ROW_TICK} row_kind_t;
  typedef enum {CHK_MODEL, CHK_SILENT, CHK_LITERAL} row_check_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         reg_idx;
    logic [31:0]        data;
    bit                 rs;
    row_check_t         chk;
    logic signed [14:0] lit_sample;
    bit                 lit_last;
  } plan_row_t;

  // DUT ports
  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               restart = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] sample;
  logic               last;

  // tone predictor state and configuration
  int          sine_lut [LUT_DEPTH];
  bit [31:0]   step_cfg;
  bit [15:0]   len_cfg;
  bit [14:0]   fade_cfg;
  bit [15:0]   pos_index;
  bit [31:0]   phase_acc;
  bit          clip_idle;

  tone_result_t expected_samples [$];
  plan_row_t    directed_plan [$];
  int           error_count = 0;
  int           hold_left = 0;
  bit           quiet = 1'b0;
  bit           block_busy = 1'b0;

  sine_beep_generator_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .restart   (restart),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sin of a Q30 angle in [0, pi/2], Horner form up to x^11
  function automatic u64_t taylor_sin_q30(input u64_t x);
    u64_t x2, b;
    x2 = (x * x) >> 30;
    b = Q30_UNIT - x2 / 110;
    b = Q30_UNIT - ((x2 * b) >> 30) / 72;
    b = Q30_UNIT - ((x2 * b) >> 30) / 42;
    b = Q30_UNIT - ((x2 * b) >> 30) / 20;
    b = Q30_UNIT - ((x2 * b) >> 30) / 6;
    return (x * b) >> 30;
  endfunction

  // full-wave table from one quadrant, mirrored and negated
  function automatic void build_sine_lut();
    u64_t turn, r, x, s, v;
    bit [1:0] quad;
    for (int k = 0; k < LUT_DEPTH; k++) begin
      turn = (u64_t'(k) << 32) / LUT_DEPTH;
      quad = 2'((turn >> 30) & 3);
      r = turn & (Q30_UNIT - 1);
      if (quad[0]) r = Q30_UNIT - r;
      x = (r * HALF_PI_Q30) >> 30;
      s = taylor_sin_q30(x);
      v = (s * PEAK_CODE + Q30_UNIT / 2) >> 30;
      if (v > PEAK_CODE) v = PEAK_CODE;
      sine_lut[k] = quad[1] ? -int'(v) : int'(v);
    end
  endfunction

  function automatic void reset_model();
    step_cfg  = 32'd214748365;
    len_cfg   = 16'd3200;
    fade_cfg  = 15'd160;
    pos_index = '0;
    phase_acc = '0;
    clip_idle = 1'b1;
  endfunction

  function automatic void apply_cfg(input logic [1:0] idx, input logic [31:0] data);
    case (idx)
      CFG_PHASE_STEP:  step_cfg = data;
      CFG_CLIP_LENGTH: len_cfg  = data[15:0];
      CFG_FADE_LENGTH: fade_cfg = data[14:0];
      default: ;
    endcase
  endfunction

  // one tick of the tone generator; returns 1 when a sample comes out
  function automatic bit predict_tone(input bit rs, output tone_result_t res);
    u64_t lut_pos, mag, num, den;
    int entry, i, len, fade, v;
    res.sample = '0;
    res.last = 1'b0;
    if (rs) begin
      pos_index = '0;
      phase_acc = '0;
      clip_idle = 1'b0;
    end
    if (clip_idle) return 1'b0;
    if (pos_index >= len_cfg) begin
      clip_idle = 1'b1;
      return 1'b0;
    end
    lut_pos = (u64_t'(phase_acc) * LUT_DEPTH) >> PHASE_W;
    if (lut_pos >= LUT_DEPTH) lut_pos = LUT_DEPTH - 1;
    entry = sine_lut[lut_pos];
    i = pos_index;
    len = len_cfg;
    fade = fade_cfg;
    // fade-out ramp wins where both ramps overlap
    if (fade == 0) begin
      num = 1;
      den = 1;
    end else begin
      den = u64_t'(fade);
      if (i > len - fade) num = u64_t'(len - i);
      else if (i < fade) num = u64_t'(i);
      else num = u64_t'(fade);
    end
    mag = u64_t'(entry < 0 ? -entry : entry);
    mag = (mag * TONE_LEVEL * num) / (PEAK_CODE * den);
    if (mag > TONE_LEVEL) mag = TONE_LEVEL;
    v = entry < 0 ? -int'(mag) : int'(mag);
    res.sample = v[14:0];
    res.last = (pos_index + 1 == len_cfg);
    phase_acc = phase_acc + step_cfg;
    pos_index = pos_index + 16'd1;
    if (res.last) clip_idle = 1'b1;
    return 1'b1;
  endfunction

  function automatic void add_cfg(input logic [1:0] idx, input logic [31:0] data);
    plan_row_t row;
    row = '{ROW_CFG, idx, data, 1'b0, CHK_MODEL, '0, 1'b0};
    directed_plan.push_back(row);
  endfunction

  function automatic void add_tick(input bit rs, input row_check_t chk = CHK_MODEL,
                                   input int lit_s = 0, input bit lit_l = 1'b0);
    plan_row_t row;
    row = '{ROW_TICK, 2'd0, 32'd0, rs, chk, lit_s[14:0], lit_l};
    directed_plan.push_back(row);
  endfunction

  // offer one tick item, with random gaps ahead of it
  task automatic send_tick(input bit rs);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    block_busy = 1'b1;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_cfg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait for all samples, then let any silent tick finish
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    block_busy = 1'b0;
  endtask

  // tick and predict, queueing what the predictor gives
  task automatic tick_and_predict(input bit rs, output bit got);
    tone_result_t res;
    send_tick(rs);
    got = predict_tone(rs, res);
    if (got) expected_samples.push_back(res);
  endtask

  // receiver back-pressure: random, quiet, or one long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // compare each sample leaving the block with the oldest expectation
  always @(posedge clk) begin : check_samples
    tone_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected item: sample %0d last %0b", sample, last);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (sample !== want.sample) begin
          $error("field sample: expected %0d, actual %0d", want.sample, sample);
          error_count++;
        end
        if (last !== want.last) begin
          $error("field last: expected %0b, actual %0b", want.last, last);
          error_count++;
        end
      end
    end
  end

  // watchdog
  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    plan_row_t    row;
    tone_result_t res;
    bit           got;
    bit           rs;
    int           productive, phase_no, n, pick;
    logic [31:0]  data;

    build_sine_lut();
    reset_model();

    // directed plan: idle after reset, ramps, zero fade, clip shortened
    // under the index, zero-length clip, one-sample clip, longest clip,
    // peak levels, ignored register index, overlapping ramps, mid-clip restart
    add_tick(1'b0, CHK_SILENT);
    add_tick(1'b1, CHK_LITERAL, 0, 1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_cfg(CFG_FADE_LENGTH, 32'd0);
    add_tick(1'b0);
    add_cfg(CFG_PHASE_STEP, 32'h4000_0000);
    add_tick(1'b0);
    add_tick(1'b0);
    add_cfg(CFG_CLIP_LENGTH, 32'd2);
    add_tick(1'b0, CHK_SILENT);
    add_tick(1'b0, CHK_SILENT);
    add_cfg(CFG_CLIP_LENGTH, 32'd0);
    add_tick(1'b1, CHK_SILENT);
    add_cfg(CFG_CLIP_LENGTH, 32'd1);
    add_cfg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
    add_cfg(CFG_FADE_LENGTH, 32'd32767);
    add_tick(1'b1, CHK_LITERAL, 0, 1'b1);
    add_tick(1'b0, CHK_SILENT);
    add_cfg(CFG_CLIP_LENGTH, 32'd65535);
    add_tick(1'b1, CHK_LITERAL, 0, 1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b0);
    add_cfg(CFG_CLIP_LENGTH, 32'd4);
    add_cfg(CFG_PHASE_STEP, 32'h4000_0000);
    add_cfg(CFG_FADE_LENGTH, 32'd0);
    add_tick(1'b1, CHK_LITERAL, 0, 1'b0);
    add_tick(1'b0, CHK_LITERAL, 12000, 1'b0);
    add_tick(1'b0, CHK_LITERAL, 0, 1'b0);
    add_tick(1'b0, CHK_LITERAL, -12000, 1'b1);
    add_tick(1'b0, CHK_SILENT);
    add_cfg(CFG_UNUSED, 32'hA5A5_5A5A);
    add_cfg(CFG_CLIP_LENGTH, 32'd3);
    add_cfg(CFG_FADE_LENGTH, 32'd2);
    add_tick(1'b1);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // walk the directed plan
    for (int k = 0; k < directed_plan.size(); k++) begin
      row = directed_plan[k];
      if (row.kind == ROW_CFG) begin
        if (block_busy) settle_block();
        write_reg(row.reg_idx, row.data);
      end else begin
        send_tick(row.rs);
        got = predict_tone(row.rs, res);
        case (row.chk)
          CHK_MODEL: if (got) expected_samples.push_back(res);
          CHK_LITERAL: begin
            res.sample = row.lit_sample;
            res.last = row.lit_last;
            expected_samples.push_back(res);
          end
          default: ;
        endcase
      end
    end

    // random phases: new settings, then mostly whole clips
    productive = 0;
    phase_no = 0;
    while (productive < RANDOM_RESULTS) begin
      if (block_busy) settle_block();
      quiet = (phase_no >= 8 && phase_no < 16);

      if (phase_no == 3) begin
        // long receiver hold-off while a full clip is offered
        write_reg(CFG_CLIP_LENGTH, 32'd40);
        hold_left = PRESSURE_HOLD;
      end else begin
        if (phase_no == 0 || $urandom_range(1)) begin
          pick = $urandom_range(9);
          case (pick)
            0: data = 32'd0;
            1: data = 32'hFFFF_FFFF;
            2, 3, 4: data = $urandom_range(32'h0100_0000, 1);
            default: data = $urandom();
          endcase
          write_reg(CFG_PHASE_STEP, data);
        end
        if (phase_no == 0 || $urandom_range(1)) begin
          data = $urandom_range(1) ? $urandom() : 32'd0;
          pick = $urandom_range(19);
          case (pick)
            0: data[15:0] = 16'd0;
            1: data[15:0] = 16'hFFFF;
            2: data[15:0] = 16'($urandom_range(65535, 41));
            default: data[15:0] = 16'($urandom_range(40, 1));
          endcase
          write_reg(CFG_CLIP_LENGTH, data);
        end
        if (phase_no == 0 || $urandom_range(1)) begin
          data = $urandom_range(1) ? $urandom() : 32'd0;
          pick = $urandom_range(9);
          case (pick)
            0: data[14:0] = 15'd0;
            1: data[14:0] = 15'h7FFF;
            2: data[14:0] = 15'($urandom_range(32767, 0));
            default: data[14:0] = 15'($urandom_range(44, 0));
          endcase
          write_reg(CFG_FADE_LENGTH, data);
        end
      end

      if (phase_no == 3 || $urandom_range(99) < 85) begin
        // the clip and two idle ticks (at most TICKS_PER_PHASE), usually from a restart;
        // the hold-off clip always restarts so the block fills up
        n = int'(len_cfg) + 2;
        if (n > TICKS_PER_PHASE) n = TICKS_PER_PHASE;
        for (int t = 0; t < n; t++) begin
          rs = (t == 0) ? (phase_no == 3 || $urandom_range(4) != 0) : 1'b0;
          tick_and_predict(rs, got);
          if (got) productive++;
        end
      end else begin
        // noise: restarts scattered at random
        n = $urandom_range(30, 1);
        for (int t = 0; t < n; t++) begin
          rs = ($urandom_range(3) == 0);
          tick_and_predict(rs, got);
          if (got) productive++;
        end
      end
      phase_no++;
    end

    settle_block();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
